// ===== sv/bcp_pkg.sv =====
package bcp_pkg;

  // Parameter format: Q1.16, one is 2^16
  localparam int unsigned PARAM_BITS = 16;
  localparam logic [PARAM_BITS:0] PARAM_ONE = 17'h1_0000;

  // Datapath widths
  localparam int unsigned COORD_W = 32;                 // coordinate field
  localparam int unsigned POW_W   = 3 * PARAM_BITS;     // cubes and cubic coefficients
  localparam int unsigned RES_W   = 82;                 // residual c, d
  localparam int unsigned PROD_W  = RES_W + POW_W;      // full multiplier product
  localparam int unsigned NUM_W   = 128;                // numerator
  localparam int unsigned DEN_W   = 80;                 // scaled denominator
  localparam int unsigned QUO_W   = 33;                 // quotient bits kept
  localparam int unsigned SHR_W   = PARAM_BITS - 1;     // numerator pre-shift
  localparam int unsigned MAG_W   = NUM_W - SHR_W;      // shifted magnitude
  localparam int unsigned LANES   = 4;                  // one_x, one_y, two_x, two_y

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic        [PARAM_BITS:0] param_first;
    logic        [PARAM_BITS:0] param_second;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] ctrl_one_x;
    logic signed [COORD_W-1:0] ctrl_one_y;
    logic signed [COORD_W-1:0] ctrl_two_x;
    logic signed [COORD_W-1:0] ctrl_two_y;
    logic                      degenerate;
    logic                      saturated;
  } out_t;

  // Cubic weights and numerator coefficients of one item
  typedef struct packed {
    logic [POW_W-1:0] u3;
    logic [POW_W-1:0] a3;
    logic [POW_W-1:0] v3;
    logic [POW_W-1:0] b3;
    logic [POW_W-1:0] k1;   // b*v^2
    logic [POW_W-1:0] k2;   // a*u^2
    logic [POW_W-1:0] k3;   // u*a^2
    logic [POW_W-1:0] k4;   // v*b^2
  } coef_t;

endpackage

// ===== sv/bcp_mul.sv =====
module bcp_mul (
  input  logic                                clk_i,
  input  logic signed [bcp_pkg::RES_W-1:0]    a_i,
  input  logic        [bcp_pkg::POW_W-1:0]    b_i,
  output logic signed [bcp_pkg::PROD_W-1:0]   p_o
);

  localparam int unsigned PP_W = 58;
  localparam int unsigned T_W  = bcp_pkg::RES_W;

  logic signed [32:0]     limb_a [3];
  logic signed [24:0]     limb_b [2];
  logic signed [PP_W-1:0] pp_d [3][2];
  logic signed [PP_W-1:0] pp_q [3][2];
  logic signed [T_W-1:0]  t_d [3];
  logic signed [T_W-1:0]  t_q [3];
  logic signed [bcp_pkg::PROD_W-1:0] p_d;
  logic signed [bcp_pkg::PROD_W-1:0] p_q;

  // Split into 32-bit by 24-bit partial products
  always_comb begin
    limb_a[0] = $signed({1'b0, a_i[31:0]});
    limb_a[1] = $signed({1'b0, a_i[63:32]});
    limb_a[2] = 33'($signed(a_i[81:64]));
    limb_b[0] = $signed({1'b0, b_i[23:0]});
    limb_b[1] = $signed({1'b0, b_i[47:24]});
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 2; j++) begin
        pp_d[i][j] = PP_W'(limb_a[i]) * PP_W'(limb_b[j]);
      end
    end
  end

  // Merge the two halves of b per limb of a
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_d[i] = T_W'(pp_q[i][0]) + (T_W'(pp_q[i][1]) <<< 24);
    end
  end

  // Final weighted sum
  assign p_d = bcp_pkg::PROD_W'(t_q[0])
             + (bcp_pkg::PROD_W'(t_q[1]) <<< 32)
             + (bcp_pkg::PROD_W'(t_q[2]) <<< 64);

  always_ff @(posedge clk_i) begin
    pp_q <= pp_d;
    t_q  <= t_d;
    p_q  <= p_d;
  end

  assign p_o = p_q;

endmodule

// ===== sv/bcp_coef.sv =====
module bcp_coef (
  input  logic                              clk_i,
  input  logic [bcp_pkg::PARAM_BITS-1:0]    u_i,
  input  logic [bcp_pkg::PARAM_BITS-1:0]    a_i,
  input  logic [bcp_pkg::PARAM_BITS-1:0]    v_i,
  input  logic [bcp_pkg::PARAM_BITS-1:0]    b_i,
  input  logic [bcp_pkg::PARAM_BITS-1:0]    w_i,
  output bcp_pkg::coef_t                    coef_o,
  output logic [bcp_pkg::DEN_W-1:0]         m_o
);

  localparam int unsigned PB  = bcp_pkg::PARAM_BITS;
  localparam int unsigned SQW = 2 * PB;
  localparam int unsigned CW  = bcp_pkg::POW_W;
  localparam int unsigned QW  = 4 * PB;
  localparam int unsigned DW  = bcp_pkg::DEN_W;

  logic [SQW-1:0] u2_q, a2_q, v2_q, b2_q, ua_q, vb_q;
  logic [PB-1:0]  u_q, a_q, v_q, b_q, w_q, w2_q;
  bcp_pkg::coef_t coef_q;
  logic [QW-1:0]  uavb_q;
  logic [DW-1:0]  m0_q, m_q;

  always_ff @(posedge clk_i) begin
    // squares and mixed products
    u2_q <= SQW'(u_i) * SQW'(u_i);
    a2_q <= SQW'(a_i) * SQW'(a_i);
    v2_q <= SQW'(v_i) * SQW'(v_i);
    b2_q <= SQW'(b_i) * SQW'(b_i);
    ua_q <= SQW'(u_i) * SQW'(a_i);
    vb_q <= SQW'(v_i) * SQW'(b_i);
    u_q  <= u_i;
    a_q  <= a_i;
    v_q  <= v_i;
    b_q  <= b_i;
    w_q  <= w_i;
    // cubes and numerator weights
    coef_q.u3 <= CW'(u2_q) * CW'(u_q);
    coef_q.a3 <= CW'(a2_q) * CW'(a_q);
    coef_q.v3 <= CW'(v2_q) * CW'(v_q);
    coef_q.b3 <= CW'(b2_q) * CW'(b_q);
    coef_q.k1 <= CW'(v2_q) * CW'(b_q);
    coef_q.k2 <= CW'(u2_q) * CW'(a_q);
    coef_q.k3 <= CW'(a2_q) * CW'(u_q);
    coef_q.k4 <= CW'(b2_q) * CW'(v_q);
    uavb_q    <= QW'(ua_q) * QW'(vb_q);
    w2_q      <= w_q;
    // u*a*v*b*|v-u|, then times three
    m0_q <= DW'(uavb_q) * DW'(w2_q);
    m_q  <= m0_q + {m0_q[DW-2:0], 1'b0};
  end

  assign coef_o = coef_q;
  assign m_o    = m_q;

endmodule

// ===== sv/bcp_div.sv =====
module bcp_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              vld_i,
  input  logic signed [bcp_pkg::NUM_W-1:0]  n_i [bcp_pkg::LANES],
  input  logic [bcp_pkg::DEN_W-1:0]         m_i,
  input  logic                              deg_i,
  input  logic                              dneg_i,
  output logic                              done_o,
  output bcp_pkg::out_t                     res_o
);

  localparam int unsigned L   = bcp_pkg::LANES;
  localparam int unsigned NW  = bcp_pkg::NUM_W;
  localparam int unsigned MW  = bcp_pkg::DEN_W;
  localparam int unsigned QW  = bcp_pkg::QUO_W;
  localparam int unsigned GW  = bcp_pkg::MAG_W;
  localparam int unsigned SH  = bcp_pkg::SHR_W;
  localparam int unsigned CW  = bcp_pkg::COORD_W;
  localparam int unsigned NST = QW;

  // magnitude stage
  logic [NW-1:0] abs_d [L];
  logic [GW-1:0] mag_q [L];
  logic [L-1:0]  neg1_q;
  logic [MW-1:0] m1_q;
  logic          deg1_q, vld1_q;

  // divider stages, index 0 holds the setup
  logic [MW-1:0] rem_d [NST+1][L];
  logic [MW-1:0] rem_q [NST+1][L];
  logic [QW-1:0] lq_d [NST+1][L];
  logic [QW-1:0] lq_q [NST+1][L];
  logic [L-1:0]  ovf_q [NST+1];
  logic [L-1:0]  neg_q [NST+1];
  logic [MW-1:0] m_q [NST+1];
  logic          deg_q [NST+1];
  logic [NST:0]  vld_q;
  logic [MW:0]   sh_v [NST][L];
  logic          ge_v [NST][L];
  logic [L-1:0]  ovf_d;

  // rounding and clamping
  logic [QW:0]     rnd_v [L];
  logic [QW-1:0]   lim_v [L];
  logic [QW-1:0]   mv_v [L];
  logic [L-1:0]    sat_v;
  logic [CW-1:0]   val_v [L];
  bcp_pkg::out_t   res_d, res_q;
  logic            done_q;

  // take magnitude and drop the 15 low bits, a division by 2^15
  always_comb begin
    for (int l = 0; l < L; l++) begin
      abs_d[l] = n_i[l][NW-1] ? NW'(-n_i[l]) : NW'(n_i[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < L; l++) begin
      mag_q[l]  <= abs_d[l][NW-1:SH];
      neg1_q[l] <= n_i[l][NW-1] ^ dneg_i;
    end
    m1_q   <= m_i;
    deg1_q <= deg_i;
  end

  // setup with overflow check, then one quotient bit per stage
  always_comb begin
    for (int l = 0; l < L; l++) begin
      ovf_d[l]    = mag_q[l][GW-1:QW] >= m1_q;
      rem_d[0][l] = mag_q[l][GW-1:QW];
      lq_d[0][l]  = mag_q[l][QW-1:0];
    end
    for (int g = 0; g < NST; g++) begin
      for (int l = 0; l < L; l++) begin
        sh_v[g][l]      = {rem_q[g][l], lq_q[g][l][QW-1]};
        ge_v[g][l]      = sh_v[g][l] >= {1'b0, m_q[g]};
        rem_d[g+1][l]   = ge_v[g][l] ? MW'(sh_v[g][l] - {1'b0, m_q[g]})
                                     : sh_v[g][l][MW-1:0];
        lq_d[g+1][l]    = {lq_q[g][l][QW-2:0], ge_v[g][l]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    lq_q     <= lq_d;
    ovf_q[0] <= ovf_d;
    neg_q[0] <= neg1_q;
    m_q[0]   <= m1_q;
    deg_q[0] <= deg1_q;
    for (int g = 0; g < NST; g++) begin
      ovf_q[g+1] <= ovf_q[g];
      neg_q[g+1] <= neg_q[g];
      m_q[g+1]   <= m_q[g];
      deg_q[g+1] <= deg_q[g];
    end
  end

  // round half away from zero, clamp, apply sign
  always_comb begin
    for (int l = 0; l < L; l++) begin
      rnd_v[l] = ({1'b0, lq_q[NST][l]} + (QW+1)'(1)) >> 1;
      lim_v[l] = neg_q[NST][l] ? QW'(33'h0_8000_0000) : QW'(33'h0_7FFF_FFFF);
      sat_v[l] = ovf_q[NST][l] || (rnd_v[l][QW-1:0] > lim_v[l]);
      mv_v[l]  = sat_v[l] ? lim_v[l] : rnd_v[l][QW-1:0];
      val_v[l] = neg_q[NST][l] ? CW'(-mv_v[l]) : CW'(mv_v[l]);
    end
    res_d.ctrl_one_x = deg_q[NST] ? '0 : $signed(val_v[0]);
    res_d.ctrl_one_y = deg_q[NST] ? '0 : $signed(val_v[1]);
    res_d.ctrl_two_x = deg_q[NST] ? '0 : $signed(val_v[2]);
    res_d.ctrl_two_y = deg_q[NST] ? '0 : $signed(val_v[3]);
    res_d.degenerate = deg_q[NST];
    res_d.saturated  = !deg_q[NST] && (|sat_v);
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld1_q <= vld_i;
      vld_q  <= {vld_q[NST-1:0], vld1_q};
      done_q <= vld_q[NST];
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== sv/bezier_control_points_from_curve.sv =====
// Throughput: one item per clock cycle; busy is never raised.
// The 33-stage restoring divider, one quotient bit per stage, sets the depth.
// Reset clears only the valid bits; no result is produced for a reset-time slot.
// The receiver cannot stall: each result is shown for exactly one cycle.
module bezier_control_points_from_curve (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  bcp_pkg::in_t  data_i,
  output logic          done_o,
  output bcp_pkg::out_t result_o
);

  localparam int unsigned PB  = bcp_pkg::PARAM_BITS;
  localparam int unsigned RW  = bcp_pkg::RES_W;
  localparam int unsigned PW  = bcp_pkg::PROD_W;
  localparam int unsigned NW  = bcp_pkg::NUM_W;
  localparam int unsigned MW  = bcp_pkg::DEN_W;
  localparam int unsigned L   = bcp_pkg::LANES;
  localparam int unsigned FLD = 10;   // delay from input register to numerator register

  // parameter clamp and degenerate check
  logic [PB:0]   uc, vc, ac, bc, wc;
  logic          deg_c, dneg_c;
  logic [PB-1:0] u1_q, a1_q, v1_q, b1_q, w1_q;

  // delay lines
  bcp_pkg::in_t   in_q [6];
  logic [1:0]     flg_q [FLD+1];
  logic [FLD:0]   vld_q;
  bcp_pkg::coef_t coef;
  bcp_pkg::coef_t kd_q [4];
  logic [MW-1:0]  m_c;
  logic [MW-1:0]  md_q [6];

  // residual and numerator datapath, index 0 is x, 1 is y
  logic signed [31:0]   st_v [2], en_v [2], p1_v [2], p2_v [2];
  logic signed [PW-1:0] as_p [2], ue_p [2], bs_p [2], ve_p [2];
  logic signed [RW-1:0] c_q [2], d_q [2];
  logic signed [PW-1:0] ck1_p [2], dk2_p [2], dk3_p [2], ck4_p [2];
  logic signed [NW-1:0] n_q [L];

  assign busy = 1'b0;

  always_comb begin
    uc = (data_i.param_first  > bcp_pkg::PARAM_ONE) ? bcp_pkg::PARAM_ONE : data_i.param_first;
    vc = (data_i.param_second > bcp_pkg::PARAM_ONE) ? bcp_pkg::PARAM_ONE : data_i.param_second;
    ac = bcp_pkg::PARAM_ONE - uc;
    bc = bcp_pkg::PARAM_ONE - vc;
    dneg_c = vc < uc;
    wc = dneg_c ? (uc - vc) : (vc - uc);
    deg_c = (uc == '0) || (vc == '0) || (uc == bcp_pkg::PARAM_ONE)
         || (vc == bcp_pkg::PARAM_ONE) || (uc == vc);
  end

  // load and delay the item
  always_ff @(posedge clk_i) begin
    in_q[0]  <= data_i;
    u1_q     <= uc[PB-1:0];
    a1_q     <= ac[PB-1:0];
    v1_q     <= vc[PB-1:0];
    b1_q     <= bc[PB-1:0];
    w1_q     <= wc[PB-1:0];
    flg_q[0] <= {deg_c, dneg_c};
    for (int i = 1; i < 6; i++) begin
      in_q[i] <= in_q[i-1];
    end
    for (int i = 1; i <= FLD; i++) begin
      flg_q[i] <= flg_q[i-1];
    end
    kd_q[0] <= coef;
    for (int i = 1; i < 4; i++) begin
      kd_q[i] <= kd_q[i-1];
    end
    md_q[0] <= m_c;
    for (int i = 1; i < 6; i++) begin
      md_q[i] <= md_q[i-1];
    end
  end

  // advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[FLD-1:0], start && !busy};
    end
  end

  bcp_coef u_coef (
    .clk_i  (clk_i),
    .u_i    (u1_q),
    .a_i    (a1_q),
    .v_i    (v1_q),
    .b_i    (b1_q),
    .w_i    (w1_q),
    .coef_o (coef),
    .m_o    (m_c)
  );

  always_comb begin
    st_v[0] = in_q[2].start_x;
    st_v[1] = in_q[2].start_y;
    en_v[0] = in_q[2].end_x;
    en_v[1] = in_q[2].end_y;
    p1_v[0] = in_q[5].first_x;
    p1_v[1] = in_q[5].first_y;
    p2_v[0] = in_q[5].second_x;
    p2_v[1] = in_q[5].second_y;
  end

  for (genvar k = 0; k < 2; k++) begin : g_coord
    // weighted end points
    bcp_mul u_mul_as (.clk_i(clk_i), .a_i(RW'(st_v[k])), .b_i(coef.a3), .p_o(as_p[k]));
    bcp_mul u_mul_ue (.clk_i(clk_i), .a_i(RW'(en_v[k])), .b_i(coef.u3), .p_o(ue_p[k]));
    bcp_mul u_mul_bs (.clk_i(clk_i), .a_i(RW'(st_v[k])), .b_i(coef.b3), .p_o(bs_p[k]));
    bcp_mul u_mul_ve (.clk_i(clk_i), .a_i(RW'(en_v[k])), .b_i(coef.v3), .p_o(ve_p[k]));

    // residuals of the two curve points
    always_ff @(posedge clk_i) begin
      c_q[k] <= (RW'(p1_v[k]) <<< (3 * PB)) - RW'(as_p[k]) - RW'(ue_p[k]);
      d_q[k] <= (RW'(p2_v[k]) <<< (3 * PB)) - RW'(bs_p[k]) - RW'(ve_p[k]);
    end

    // numerator terms
    bcp_mul u_mul_ck1 (.clk_i(clk_i), .a_i(c_q[k]), .b_i(kd_q[3].k1), .p_o(ck1_p[k]));
    bcp_mul u_mul_dk2 (.clk_i(clk_i), .a_i(d_q[k]), .b_i(kd_q[3].k2), .p_o(dk2_p[k]));
    bcp_mul u_mul_dk3 (.clk_i(clk_i), .a_i(d_q[k]), .b_i(kd_q[3].k3), .p_o(dk3_p[k]));
    bcp_mul u_mul_ck4 (.clk_i(clk_i), .a_i(c_q[k]), .b_i(kd_q[3].k4), .p_o(ck4_p[k]));

    always_ff @(posedge clk_i) begin
      n_q[k]     <= NW'(ck1_p[k]) - NW'(dk2_p[k]);
      n_q[k + 2] <= NW'(dk3_p[k]) - NW'(ck4_p[k]);
    end
  end

  bcp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (vld_q[FLD]),
    .n_i    (n_q),
    .m_i    (md_q[5]),
    .deg_i  (flg_q[FLD][1]),
    .dneg_i (flg_q[FLD][0]),
    .done_o (done_o),
    .res_o  (result_o)
  );

endmodule

// ===== tb/sv/tb_bezier_control_points_from_curve.sv =====
`timescale 1ns / 100ps

module tb_bezier_control_points_from_curve;

  localparam int N_RANDOM    = 1500;
  localparam int LATENCY     = 47;
  localparam int CYCLE_LIMIT = 200000;

  // Expected control points and checks of received results
  class ctrl_point_board;
    bcp_pkg::out_t pending_points[$];
    int   mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Round |n| / (3 * 2^16 * u*a*v*b*|v-u|) to nearest and clamp to 32 bits
    function logic [31:0] scale_coord(logic [127:0] num, bit den_neg,
                                      logic [16:0] u, logic [16:0] a,
                                      logic [16:0] v, logic [16:0] b,
                                      logic [16:0] gap, inout bit sat);
      bit          neg;
      logic [127:0] mag;
      logic [63:0]  limit, r;
      neg = num[127];
      mag = neg ? -num : num;
      mag = mag << 1;
      mag = mag / 128'd3;
      mag = mag / 128'd65536;
      mag = mag / u;
      mag = mag / a;
      mag = mag / v;
      mag = mag / b;
      mag = mag / gap;
      neg = neg ^ den_neg;
      limit = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      if (mag[127:33] != 0) r = limit + 1;
      else r = ({31'b0, mag[32:0]} + 64'd1) >> 1;
      if (r > limit) begin
        r = limit;
        sat = 1'b1;
      end
      if (neg) r = -r;
      return r[31:0];
    endfunction

    // pt*2^48 - a^3*start - t^3*end, modulo 2^128
    function logic [127:0] curve_residual(logic [31:0] pt, logic [31:0] st,
                                          logic [31:0] en, logic [16:0] t,
                                          logic [16:0] a);
      logic [127:0] pw, sw, ew, t3, a3;
      pw = {{96{pt[31]}}, pt};
      sw = {{96{st[31]}}, st};
      ew = {{96{en[31]}}, en};
      t3 = 128'(t) * t * t;
      a3 = 128'(a) * a * a;
      return (pw << 48) - sw * a3 - ew * t3;
    endfunction

    function bcp_pkg::out_t predict_ctrl_points(bcp_pkg::in_t item);
      bcp_pkg::out_t res;
      logic [16:0]  u, v, a, b, gap;
      logic [31:0]  st[2], p1[2], p2[2], en[2], one[2], two[2];
      logic [127:0] c, d, n1, n2;
      bit           den_neg, sat;
      u = (item.param_first > bcp_pkg::PARAM_ONE) ? bcp_pkg::PARAM_ONE : item.param_first;
      v = (item.param_second > bcp_pkg::PARAM_ONE) ? bcp_pkg::PARAM_ONE : item.param_second;
      a = bcp_pkg::PARAM_ONE - u;
      b = bcp_pkg::PARAM_ONE - v;
      res = '0;
      if (u == 0 || v == 0 || a == 0 || b == 0 || u == v) begin
        res.degenerate = 1'b1;
        return res;
      end
      den_neg = v < u;
      gap = den_neg ? u - v : v - u;
      sat = 1'b0;
      st = '{item.start_x, item.start_y};
      p1 = '{item.first_x, item.first_y};
      p2 = '{item.second_x, item.second_y};
      en = '{item.end_x, item.end_y};
      for (int k = 0; k < 2; k++) begin
        c = curve_residual(p1[k], st[k], en[k], u, a);
        d = curve_residual(p2[k], st[k], en[k], v, b);
        n1 = c * (128'(b) * v * v) - d * (128'(a) * u * u);
        n2 = d * (128'(a) * a * u) - c * (128'(b) * b * v);
        one[k] = scale_coord(n1, den_neg, u, a, v, b, gap, sat);
        two[k] = scale_coord(n2, den_neg, u, a, v, b, gap, sat);
      end
      res.ctrl_one_x = one[0];
      res.ctrl_one_y = one[1];
      res.ctrl_two_x = two[0];
      res.ctrl_two_y = two[1];
      res.saturated  = sat;
      return res;
    endfunction

    function void note_transfer(bcp_pkg::in_t item);
      pending_points.push_back(predict_ctrl_points(item));
    endfunction

    function void check_result(bcp_pkg::out_t got);
      bcp_pkg::out_t want;
      if (pending_points.size() == 0) begin
        $error("result with no expectation pending");
        mismatches++;
        return;
      end
      want = pending_points.pop_front();
      if (got.ctrl_one_x !== want.ctrl_one_x) begin
        $error("ctrl_one_x: expected %h, got %h", want.ctrl_one_x, got.ctrl_one_x);
        mismatches++;
      end
      if (got.ctrl_one_y !== want.ctrl_one_y) begin
        $error("ctrl_one_y: expected %h, got %h", want.ctrl_one_y, got.ctrl_one_y);
        mismatches++;
      end
      if (got.ctrl_two_x !== want.ctrl_two_x) begin
        $error("ctrl_two_x: expected %h, got %h", want.ctrl_two_x, got.ctrl_two_x);
        mismatches++;
      end
      if (got.ctrl_two_y !== want.ctrl_two_y) begin
        $error("ctrl_two_y: expected %h, got %h", want.ctrl_two_y, got.ctrl_two_y);
        mismatches++;
      end
      if (got.degenerate !== want.degenerate) begin
        $error("degenerate: expected %b, got %b", want.degenerate, got.degenerate);
        mismatches++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated: expected %b, got %b", want.saturated, got.saturated);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  bcp_pkg::in_t  data_i = '0;
  logic done_o;
  bcp_pkg::out_t result_o;

  ctrl_point_board board = new();
  int  cycles = 0;
  bit  idle_allowed = 1'b1;

  bezier_control_points_from_curve dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .data_i  (data_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watch both sides on the edge and bound the run
  always @(posedge clk_i) begin
    cycles++;
    if (rst_ni && start && !busy) board.note_transfer(data_i);
    if (rst_ni && done_o) board.check_result(result_o);
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Hold one item until the block takes it, idling now and then
  task automatic send_item(bcp_pkg::in_t item);
    bit taken;
    while (idle_allowed && $urandom_range(99) < 11) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start  <= 1'b1;
    data_i <= item;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !busy;
    end
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return 32'($signed($urandom_range(2000000)) - 1000000);
      default: return 32'($signed($urandom_range(200)) - 100) << 16;
    endcase
  endfunction

  function automatic logic [16:0] pick_param();
    case ($urandom_range(19))
      0: return 17'($urandom_range(17'h1FFFF));
      1: return $urandom_range(1) ? 17'd0 : bcp_pkg::PARAM_ONE;
      2: return $urandom_range(1) ? 17'd1 : 17'hFFFF;
      default: return 17'($urandom_range(17'hFFFF, 17'd1));
    endcase
  endfunction

  function automatic bcp_pkg::in_t random_item();
    bcp_pkg::in_t item;
    item.start_x = pick_coord();
    item.start_y = pick_coord();
    item.first_x = pick_coord();
    item.first_y = pick_coord();
    item.second_x = pick_coord();
    item.second_y = pick_coord();
    item.end_x = pick_coord();
    item.end_y = pick_coord();
    item.param_first = pick_param();
    item.param_second = pick_param();
    // Sometimes place the two parameters close together
    if ($urandom_range(9) == 0 && item.param_first < 17'hFFF0)
      item.param_second = 17'(item.param_first + $urandom_range(3));
    return item;
  endfunction

  function automatic bcp_pkg::in_t plain_item(logic [31:0] coord, logic [16:0] u,
                                              logic [16:0] v);
    bcp_pkg::in_t item;
    item.start_x = coord;
    item.start_y = ~coord;
    item.first_x = coord;
    item.first_y = ~coord;
    item.second_x = ~coord;
    item.second_y = coord;
    item.end_x = ~coord;
    item.end_y = coord;
    item.param_first = u;
    item.param_second = v;
    return item;
  endfunction

  initial begin
    bcp_pkg::in_t item;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, degenerate parameters, clamped parameters, saturation
    send_item(plain_item(32'h0001_0000, 17'h4000, 17'hC000));
    send_item(plain_item(32'h7FFF_FFFF, 17'h4000, 17'hC000));
    send_item(plain_item(32'h8000_0000, 17'h4000, 17'hC000));
    send_item(plain_item(32'h0000_0000, 17'h8000, 17'h4000));
    send_item(plain_item(32'h1234_5678, 17'd0, 17'h8000));
    send_item(plain_item(32'h1234_5678, 17'h8000, 17'd0));
    send_item(plain_item(32'h1234_5678, bcp_pkg::PARAM_ONE, 17'h8000));
    send_item(plain_item(32'h1234_5678, 17'h8000, bcp_pkg::PARAM_ONE));
    send_item(plain_item(32'h1234_5678, 17'h5555, 17'h5555));
    send_item(plain_item(32'h1234_5678, 17'h1FFFF, 17'h8000));
    send_item(plain_item(32'h1234_5678, 17'h8000, 17'h1_8001));
    send_item(plain_item(32'h7FFF_FFFF, 17'h8000, 17'h8001));
    send_item(plain_item(32'h8000_0000, 17'h8001, 17'h8000));
    send_item(plain_item(32'h7FFF_FFFF, 17'd1, 17'hFFFF));
    send_item(plain_item(32'h8000_0000, 17'hFFFF, 17'd1));
    send_item(plain_item(32'hFFFF_FFFF, 17'd1, 17'd2));
    send_item(plain_item(32'hAAAA_AAAA, 17'h0AAAA, 17'h15555));
    send_item(plain_item(32'h5555_5555, 17'h15555, 17'h0AAAA));

    // Random items, with one long stretch that never idles
    for (int i = 0; i < N_RANDOM; i++) begin
      idle_allowed = !(i >= 600 && i < 900);
      item = random_item();
      send_item(item);
    end
    start <= 1'b0;

    while (board.pending_points.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
